// ===== design/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg: shared types and constants of the set-associative LRU cache model
// Defaults, register and action codes, controller states, command/status.
// ----------------------------------------------------------------------------
package salc_pkg;

	localparam int DEF_MAX_SETS  = 256;
	localparam int DEF_MAX_WAYS  = 8;
	localparam int DEF_ADDR_BITS = 48;

	localparam int CFG_W       = 4;
	localparam int CFG_ADDR_W  = 4;
	localparam int APB_DATA_W  = 32;

	localparam logic [CFG_W-1:0] RST_SET_BITS    = 4'd4;
	localparam logic [CFG_W-1:0] RST_OFFSET_BITS = 4'd2;
	localparam logic [CFG_W-1:0] RST_WAYS        = 4'd1;

	localparam logic [1:0] REG_SET_BITS    = 2'd0;
	localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS        = 2'd2;

	localparam logic [1:0] ACT_MODIFY = 2'd2;
	localparam logic [1:0] ACT_NONE   = 2'd3;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic [CFG_W-1:0] set_bits;
		logic [CFG_W-1:0] offset_bits;
		logic [CFG_W-1:0] ways;
	} cfg_t;

	typedef struct packed {
		logic clr;
		logic take;
		logic rd;
		logic upd;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_busy;
		logic in_skip;
		logic in_mod;
	} status_t;

endpackage

// ===== design/set_assoc_lru_cache_model_unit.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model_unit: set-associative cache model, LRU replacement
// Classifies each access as hit, miss or eviction and keeps running totals.
// ----------------------------------------------------------------------------
// After reset the unit clears the valid bits and ranks of all MAX_SETS set
// rows, one set row a cycle, with in_ready low; configuration writes are
// taken throughout. Each access then reads the selected set row from the row
// memory in the read state, then compares, chooses the replacement way and
// writes the row back in the update state. A modify makes two accesses to the
// same set, and action 3 is consumed in the cycle it arrives with no result.
// The next item is taken in the update cycle of the last access; a result
// held by out_ready stalls the following update, and no item is taken while
// that update waits.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model_unit
	import salc_pkg::*;
#(
	parameter int MAX_SETS  = DEF_MAX_SETS,
	parameter int MAX_WAYS  = DEF_MAX_WAYS,
	parameter int ADDR_BITS = DEF_ADDR_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            action,
	input  logic [ADDR_BITS-1:0]  address,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  hit,
	output logic                  evicted,
	output logic                  last,
	output logic [31:0]           hit_total,
	output logic [31:0]           miss_total,
	output logic [31:0]           eviction_total
);

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t st;
	logic    cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_bits    <= RST_SET_BITS;
			cfg_q.offset_bits <= RST_OFFSET_BITS;
			cfg_q.ways        <= RST_WAYS;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_SET_BITS:    cfg_q.set_bits    <= pwdata[CFG_W-1:0];
				REG_OFFSET_BITS: cfg_q.offset_bits <= pwdata[CFG_W-1:0];
				REG_WAYS:        cfg_q.ways        <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_SET_BITS:    prdata[CFG_W-1:0] = cfg_q.set_bits;
			REG_OFFSET_BITS: prdata[CFG_W-1:0] = cfg_q.offset_bits;
			REG_WAYS:        prdata[CFG_W-1:0] = cfg_q.ways;
			default:         prdata = '0;
		endcase
	end

	salc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	salc_dpath #(
		.MAX_SETS  (MAX_SETS),
		.MAX_WAYS  (MAX_WAYS),
		.ADDR_BITS (ADDR_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd            (cmd),
		.st             (st),
		.action         (action),
		.address        (address),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.hit            (hit),
		.evicted        (evicted),
		.last           (last),
		.hit_total      (hit_total),
		.miss_total     (miss_total),
		.eviction_total (eviction_total)
	);

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && evicted))
		else $error("result flagged both hit and eviction");

	a_evict_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted |-> eviction_total != '0 && miss_total != '0)
		else $error("eviction without counted miss and eviction");

	a_totals_grow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |=> hit_total >= $past(hit_total) && miss_total >= $past(miss_total))
		else $error("running totals decreased");

	a_no_upd_while_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |-> !st.out_busy)
		else $error("result register overwritten before transfer");

endmodule

// ===== design/salc_ctrl.sv =====
// ----------------------------------------------------------------------------
// salc_ctrl: access sequencer
// Clears the line state after reset, then runs read and update of one set
// per access, twice for a modify.
// ----------------------------------------------------------------------------
module salc_ctrl
	import salc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q, state_nx;
	logic   mod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			mod_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.take) begin
				mod_q <= st.in_mod;
			end else if (cmd.upd) begin
				mod_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (st.clear_last) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd.take) state_nx = ST_READ;
			end
			ST_READ: begin
				state_nx = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (!st.out_busy) begin
					if (mod_q || cmd.take) state_nx = ST_READ;
					else state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_READ: begin
				cmd.rd = 1'b1;
			end
			ST_UPDATE: begin
				cmd.upd  = !st.out_busy;
				cmd.last = !mod_q;
				in_ready = !st.out_busy && !mod_q;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		cmd.take = in_ready && in_valid && !st.in_skip;
	end

endmodule

// ===== design/salc_dpath.sv =====
// ----------------------------------------------------------------------------
// salc_dpath: address split, tag/meta store, hit search, LRU update, totals
// One row per set holds tags, valid bits and recency ranks of all ways.
// ----------------------------------------------------------------------------
module salc_dpath
	import salc_pkg::*;
#(
	parameter int MAX_SETS  = DEF_MAX_SETS,
	parameter int MAX_WAYS  = DEF_MAX_WAYS,
	parameter int ADDR_BITS = DEF_ADDR_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  cmd_t                 cmd,
	output status_t              st,
	input  logic [1:0]           action,
	input  logic [ADDR_BITS-1:0] address,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 hit,
	output logic                 evicted,
	output logic                 last,
	output logic [31:0]          hit_total,
	output logic [31:0]          miss_total,
	output logic [31:0]          eviction_total
);

	localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int RANK_W = WAY_W;
	localparam int META_W = 1 + RANK_W;
	localparam int WCNT_W = $clog2(MAX_WAYS + 1) + 1;
	localparam int SMAX   = $clog2(MAX_SETS + 1) - 1;
	localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

	logic [MAX_WAYS*ADDR_BITS-1:0] tag_mem [MAX_SETS];
	logic [MAX_WAYS*META_W-1:0]    meta_mem [MAX_SETS];

	logic [MAX_WAYS*ADDR_BITS-1:0] tag_rd_q;
	logic [MAX_WAYS*META_W-1:0]    meta_rd_q;
	logic [SET_W-1:0]              set_q;
	logic [ADDR_BITS-1:0]          tag_q;
	logic [SET_W-1:0]              clr_idx_q;
	logic                          out_valid_q;
	logic                          out_hit_q;
	logic                          out_evict_q;
	logic                          out_last_q;
	logic [31:0]                   hit_cnt_q;
	logic [31:0]                   miss_cnt_q;
	logic [31:0]                   evict_cnt_q;

	logic [CFG_W-1:0]     s_eff;
	logic [SET_W:0]       set_mask;
	logic [ADDR_BITS-1:0] addr_sh;
	logic [SET_W-1:0]     set_nx;
	logic [ADDR_BITS-1:0] tag_nx;
	logic [WCNT_W-1:0]    ways_eff;

	logic [MAX_WAYS-1:0]  v;
	logic [MAX_WAYS-1:0]  in_use;
	logic [MAX_WAYS-1:0]  match;
	logic [MAX_WAYS-1:0]  inval;
	logic [RANK_W-1:0]    rank [MAX_WAYS];
	logic [WAY_W-1:0]     hit_way;
	logic [WAY_W-1:0]     inv_way;
	logic [WAY_W-1:0]     lru_way;
	logic [WAY_W-1:0]     sel_way;
	logic [RANK_W-1:0]    sel_rank;
	logic                 acc_hit;
	logic                 found_inv;
	logic                 was_valid;
	logic                 acc_evict;
	logic [MAX_WAYS*META_W-1:0]    new_meta;
	logic [MAX_WAYS*ADDR_BITS-1:0] new_tag;

	// address split
	always_comb begin
		s_eff    = (cfg.set_bits > CFG_W'(SMAX)) ? CFG_W'(SMAX) : cfg.set_bits;
		set_mask = ({{SET_W{1'b0}}, 1'b1} << s_eff) - {{SET_W{1'b0}}, 1'b1};
		addr_sh  = address >> cfg.offset_bits;
		set_nx   = addr_sh[SET_W-1:0] & set_mask[SET_W-1:0];
		tag_nx   = address >> ({1'b0, cfg.offset_bits} + {1'b0, s_eff});
		if (cfg.ways == '0) begin
			ways_eff = WCNT_W'(1);
		end else if (WCNT_W'(cfg.ways) > WCNT_W'(MAX_WAYS)) begin
			ways_eff = WCNT_W'(MAX_WAYS);
		end else begin
			ways_eff = WCNT_W'(cfg.ways);
		end
	end

	// search and recency update of one set row
	always_comb begin
		for (int i = 0; i < MAX_WAYS; i++) begin
			v[i]      = meta_rd_q[i*META_W];
			rank[i]   = meta_rd_q[i*META_W+1 +: RANK_W];
			in_use[i] = WCNT_W'(i) < ways_eff;
			match[i]  = in_use[i] && v[i] &&
				(tag_rd_q[i*ADDR_BITS +: ADDR_BITS] == tag_q);
			inval[i]  = in_use[i] && !v[i];
		end
		hit_way = '0;
		inv_way = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (match[i]) hit_way = WAY_W'(i);
			if (inval[i]) inv_way = WAY_W'(i);
		end
		lru_way = '0;
		for (int i = 1; i < MAX_WAYS; i++) begin
			if (in_use[i] && rank[i] > rank[lru_way]) lru_way = WAY_W'(i);
		end
		acc_hit   = |match;
		found_inv = |inval;
		sel_way   = acc_hit ? hit_way : (found_inv ? inv_way : lru_way);
		was_valid = acc_hit || !found_inv;
		acc_evict = !acc_hit && !found_inv;
		sel_rank  = rank[sel_way];
		new_meta  = meta_rd_q;
		new_tag   = tag_rd_q;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (WAY_W'(i) == sel_way) begin
				new_meta[i*META_W]              = 1'b1;
				new_meta[i*META_W+1 +: RANK_W]  = '0;
				new_tag[i*ADDR_BITS +: ADDR_BITS] = tag_q;
			end else if (in_use[i] && v[i] && (!was_valid || rank[i] < sel_rank) &&
				rank[i] < RANK_MAX) begin
				new_meta[i*META_W+1 +: RANK_W] = rank[i] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			meta_mem[clr_idx_q] <= '0;
		end else if (cmd.upd) begin
			meta_mem[set_q] <= new_meta;
			tag_mem[set_q]  <= new_tag;
		end
		if (cmd.rd) begin
			meta_rd_q <= meta_mem[set_q];
			tag_rd_q  <= tag_mem[set_q];
		end
		if (cmd.take) begin
			set_q <= set_nx;
			tag_q <= tag_nx;
		end
		if (cmd.upd) begin
			out_hit_q   <= acc_hit;
			out_evict_q <= acc_evict;
			out_last_q  <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
		end else begin
			if (cmd.clr) clr_idx_q <= clr_idx_q + 1'b1;
			if (cmd.upd) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.upd) begin
				if (acc_hit) begin
					if (hit_cnt_q != '1) hit_cnt_q <= hit_cnt_q + 1'b1;
				end else begin
					if (miss_cnt_q != '1) miss_cnt_q <= miss_cnt_q + 1'b1;
				end
				if (acc_evict && evict_cnt_q != '1) evict_cnt_q <= evict_cnt_q + 1'b1;
			end
		end
	end

	assign st.clear_last = clr_idx_q == SET_W'(MAX_SETS - 1);
	assign st.out_busy   = out_valid_q && !out_ready;
	assign st.in_skip    = action == ACT_NONE;
	assign st.in_mod     = action == ACT_MODIFY;

	assign out_valid      = out_valid_q;
	assign hit            = out_hit_q;
	assign evicted        = out_evict_q;
	assign last           = out_last_q;
	assign hit_total      = hit_cnt_q;
	assign miss_total     = miss_cnt_q;
	assign eviction_total = evict_cnt_q;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for set_assoc_lru_cache_model_unit
// Drives a directed table of accesses and register writes, then random phases
// over many cache geometries. A shadow cache predicts hit, eviction and the
// running totals of every access; results are checked against it or pinned rows.
// ----------------------------------------------------------------------------
module tb;
	import salc_pkg::*;

	localparam int MAX_SETS  = DEF_MAX_SETS;
	localparam int MAX_WAYS  = DEF_MAX_WAYS;
	localparam int ADDR_BITS = DEF_ADDR_BITS;
	localparam int NLINES    = MAX_SETS * MAX_WAYS;
	localparam int LIMIT     = 1000000;
	localparam int PHASES    = 11;
	localparam int PHASE_LEN = 150;
	localparam int MAX_POOL  = 24;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_STORE = 2'd1;

	typedef struct packed {
		logic        hit;
		logic        evicted;
		logic        last;
		logic [31:0] hits;
		logic [31:0] misses;
		logic [31:0] evicts;
	} cache_result_t;

	typedef struct {
		bit            is_reg;
		logic [1:0]    reg_id;
		logic [3:0]    value;
		logic [1:0]    act;
		logic [47:0]   addr;
		bit            pinned;
		cache_result_t pin;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  psel      = 1'b0;
	logic                  penable   = 1'b0;
	logic                  pwrite    = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr     = '0;
	logic [APB_DATA_W-1:0] pwdata    = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [1:0]            action    = ACT_LOAD;
	logic [ADDR_BITS-1:0]  address   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  hit;
	logic                  evicted;
	logic                  last;
	logic [31:0]           hit_total;
	logic [31:0]           miss_total;
	logic [31:0]           eviction_total;

	bit            pin_on  = 1'b0;
	cache_result_t pin_res = '0;

	bit          line_live [NLINES];
	logic [47:0] line_key  [NLINES];
	bit   [2:0]  line_age  [NLINES];
	bit   [31:0] n_hits;
	bit   [31:0] n_misses;
	bit   [31:0] n_evicts;
	logic [3:0]  cfg_set_bits    = RST_SET_BITS;
	logic [3:0]  cfg_offset_bits = RST_OFFSET_BITS;
	logic [3:0]  cfg_ways        = RST_WAYS;

	cache_result_t outcome_q [$];
	logic [47:0]   pool [MAX_POOL];
	int            pool_n;
	int            errors;
	int            cycles;
	int            hold_req;

	set_assoc_lru_cache_model_unit #(
		.MAX_SETS(MAX_SETS),
		.MAX_WAYS(MAX_WAYS),
		.ADDR_BITS(ADDR_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.address(address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit(hit),
		.evicted(evicted),
		.last(last),
		.hit_total(hit_total),
		.miss_total(miss_total),
		.eviction_total(eviction_total)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic bit [31:0] sat_inc(bit [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic int unsigned eff_set_bits();
		int unsigned s;
		s = 32'(cfg_set_bits);
		while (s > 0 && (1 << s) > MAX_SETS)
			s--;
		return s;
	endfunction

	function automatic int unsigned eff_ways();
		int unsigned w;
		w = 32'(cfg_ways);
		if (w < 1)
			w = 1;
		if (w > MAX_WAYS)
			w = MAX_WAYS;
		return w;
	endfunction

	function automatic void age_lines(int unsigned base, int unsigned nw, int unsigned w,
			bit was_valid);
		int unsigned k;
		for (int unsigned i = 0; i < nw; i++) begin
			k = base + i;
			if (i != w && line_live[k]) begin
				if ((!was_valid || line_age[k] < line_age[base + w]) &&
						line_age[k] < MAX_WAYS - 1)
					line_age[k] = line_age[k] + 3'd1;
			end
		end
		line_age[base + w] = 3'd0;
	endfunction

	function automatic cache_result_t classify_access(logic [47:0] key, int unsigned set);
		cache_result_t res;
		int unsigned   nw;
		int unsigned   base;
		int unsigned   pick;
		bit            found;
		bit            blank;
		res   = '0;
		nw    = eff_ways();
		base  = set * MAX_WAYS;
		pick  = 0;
		found = 1'b0;
		blank = 1'b0;
		for (int unsigned i = 0; i < nw; i++) begin
			if (!found && line_live[base + i] && line_key[base + i] == key) begin
				found = 1'b1;
				pick  = i;
			end
		end
		if (found) begin
			age_lines(base, nw, pick, 1'b1);
			n_hits = sat_inc(n_hits);
		end else begin
			n_misses = sat_inc(n_misses);
			for (int unsigned i = 0; i < nw; i++) begin
				if (!blank && !line_live[base + i]) begin
					blank = 1'b1;
					pick  = i;
				end
			end
			if (!blank) begin
				pick = 0;
				for (int unsigned i = 1; i < nw; i++)
					if (line_age[base + i] > line_age[base + pick])
						pick = i;
				res.evicted = 1'b1;
				n_evicts = sat_inc(n_evicts);
			end
			age_lines(base, nw, pick, !blank);
			line_live[base + pick] = 1'b1;
			line_key[base + pick]  = key;
		end
		res.hit    = found;
		res.hits   = n_hits;
		res.misses = n_misses;
		res.evicts = n_evicts;
		return res;
	endfunction

	function automatic void classify_item(logic [1:0] act, logic [47:0] addr, bit pinned,
			cache_result_t pin);
		int unsigned   s;
		int unsigned   b;
		int unsigned   set;
		logic [47:0]   key;
		cache_result_t first;
		cache_result_t second;
		if (act == ACT_NONE)
			return;
		s     = eff_set_bits();
		b     = 32'(cfg_offset_bits);
		set   = 32'((addr >> b) & ((48'd1 << s) - 48'd1));
		key   = addr >> (b + s);
		first = classify_access(key, set);
		if (act == ACT_MODIFY) begin
			second     = classify_access(key, set);
			first.last = 1'b0;
			outcome_q.push_back(first);
			first = second;
		end
		first.last = 1'b1;
		if (pinned)
			first = pin;
		outcome_q.push_back(first);
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("ERROR cycle %0d: %s got %0h want %0h", cycles, what, got, want);
	endtask

	always @(posedge clk) begin : scoreboard
		cache_result_t want;
		cycles++;
		if (cycles > LIMIT) begin
			$display("set_assoc_lru_cache_model_unit regression: fail");
			$finish;
		end else if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_SET_BITS:    cfg_set_bits    = pwdata[3:0];
					REG_OFFSET_BITS: cfg_offset_bits = pwdata[3:0];
					REG_WAYS:        cfg_ways        = pwdata[3:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (outcome_q.size() == 0) begin
					report_mismatch("result with nothing expected", 64'(hit_total),
						64'(0));
				end else begin
					want = outcome_q.pop_front();
					if (hit !== want.hit)
						report_mismatch("hit", 64'(hit), 64'(want.hit));
					if (evicted !== want.evicted)
						report_mismatch("evicted", 64'(evicted), 64'(want.evicted));
					if (last !== want.last)
						report_mismatch("last", 64'(last), 64'(want.last));
					if (hit_total !== want.hits)
						report_mismatch("hit_total", 64'(hit_total), 64'(want.hits));
					if (miss_total !== want.misses)
						report_mismatch("miss_total", 64'(miss_total),
							64'(want.misses));
					if (eviction_total !== want.evicts)
						report_mismatch("eviction_total", 64'(eviction_total),
							64'(want.evicts));
				end
			end
			if (in_valid && in_ready)
				classify_item(action, address, pin_on, pin_res);
		end
	end

	always begin : receiver
		int hold_left;
		int mode;
		int mode_left;
		int tick;
		hold_left = 0;
		mode      = 0;
		mode_left = 0;
		tick      = 0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= (tick % 3 == 0);
				endcase
			end
		end
	end

	task automatic send_access(logic [1:0] act, logic [47:0] addr, bit pinned,
			cache_result_t pin);
		@(negedge clk);
		in_valid <= 1'b1;
		action   <= act;
		address  <= addr;
		pin_on   <= pinned;
		pin_res  <= pin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic pause(int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic apb_write(logic [1:0] idx, logic [3:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {28'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic plan_row_t row_access(logic [1:0] act, logic [47:0] addr);
		plan_row_t r;
		r.is_reg = 1'b0;
		r.reg_id = REG_SET_BITS;
		r.value  = '0;
		r.act    = act;
		r.addr   = addr;
		r.pinned = 1'b0;
		r.pin    = '0;
		return r;
	endfunction

	function automatic plan_row_t row_pinned(logic [1:0] act, logic [47:0] addr, bit h,
			bit e, int unsigned nh, int unsigned nm, int unsigned ne);
		plan_row_t r;
		r        = row_access(act, addr);
		r.pinned = 1'b1;
		r.pin    = {h, e, 1'b1, nh[31:0], nm[31:0], ne[31:0]};
		return r;
	endfunction

	function automatic plan_row_t row_reg(logic [1:0] idx, logic [3:0] val);
		plan_row_t r;
		r        = row_access(ACT_LOAD, '0);
		r.is_reg = 1'b1;
		r.reg_id = idx;
		r.value  = val;
		return r;
	endfunction

	function automatic void build_pool();
		int unsigned s;
		int unsigned b;
		int unsigned nsets;
		int unsigned set0;
		logic [63:0] tag;
		logic [63:0] a;
		s      = eff_set_bits();
		b      = 32'(cfg_offset_bits);
		nsets  = $urandom_range(1, 4);
		if (nsets > (1 << s))
			nsets = 1 << s;
		set0   = $urandom_range(0, (1 << s) - 1);
		pool_n = $urandom_range(2, 2 * eff_ways() + 2);
		if (pool_n > MAX_POOL)
			pool_n = MAX_POOL;
		for (int i = 0; i < pool_n; i++) begin
			if ($urandom_range(0, 1))
				tag = 64'($urandom_range(0, 15));
			else
				tag = {$urandom, $urandom};
			a = (tag << (b + s)) |
				(64'(((set0 + $urandom_range(0, nsets - 1)) & ((1 << s) - 1))) << b);
			pool[i] = a[47:0];
		end
	endfunction

	initial begin : stimulus
		plan_row_t   plan [$];
		plan_row_t   row;
		logic [3:0]  cs;
		logic [3:0]  co;
		logic [3:0]  cw;
		logic [1:0]  act;
		logic [63:0] r64;
		logic [47:0] addr;
		int          burst_left;
		int          pick;
		bit          gappy;

		plan.push_back(row_pinned(ACT_LOAD, 48'h0, 1'b0, 1'b0, 0, 1, 0));
		plan.push_back(row_pinned(ACT_LOAD, 48'h0, 1'b1, 1'b0, 1, 1, 0));
		plan.push_back(row_pinned(ACT_STORE, 48'h1, 1'b1, 1'b0, 2, 1, 0));
		plan.push_back(row_access(ACT_MODIFY, 48'h40));
		plan.push_back(row_access(ACT_NONE, 48'hFFFF_FFFF_FFFF));
		plan.push_back(row_pinned(ACT_LOAD, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 3, 3, 1));
		plan.push_back(row_pinned(ACT_LOAD, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 4, 3, 1));
		plan.push_back(row_pinned(ACT_STORE, 48'h0, 1'b0, 1'b1, 4, 4, 2));
		plan.push_back(row_reg(REG_SET_BITS, 4'd15));
		plan.push_back(row_reg(REG_OFFSET_BITS, 4'd15));
		plan.push_back(row_reg(REG_WAYS, 4'd0));
		plan.push_back(row_access(ACT_MODIFY, 48'hFFFF_FFFF_FFFF));
		plan.push_back(row_access(ACT_LOAD, 48'h8000_0000_0000));
		plan.push_back(row_reg(REG_SET_BITS, 4'd0));
		plan.push_back(row_reg(REG_OFFSET_BITS, 4'd0));
		plan.push_back(row_reg(REG_WAYS, 4'd15));
		for (int i = 0; i < 9; i++)
			plan.push_back(row_access(ACT_LOAD, 48'(16 + i)));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			row = plan[i];
			if (row.is_reg) begin
				drain();
				apb_write(row.reg_id, row.value);
			end else begin
				send_access(row.act, row.addr, row.pinned, row.pin);
				pause($urandom_range(0, 2));
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin cs = RST_SET_BITS; co = RST_OFFSET_BITS; cw = RST_WAYS; end
				1: begin cs = 4'd8;  co = 4'd12; cw = 4'd8;  end
				2: begin cs = 4'd0;  co = 4'd0;  cw = 4'd15; end
				3: begin cs = 4'd15; co = 4'd15; cw = 4'd0;  end
				4: begin cs = 4'd1;  co = 4'd3;  cw = 4'd2;  end
				default: begin
					cs = ($urandom_range(0, 4) < 3) ? 4'($urandom_range(0, 3)) :
						4'($urandom_range(0, 15));
					co = 4'($urandom_range(0, 15));
					cw = 4'($urandom_range(0, 15));
				end
			endcase
			drain();
			apb_write(REG_SET_BITS, cs);
			apb_write(REG_OFFSET_BITS, co);
			apb_write(REG_WAYS, cw);
			build_pool();
			gappy      = ($urandom_range(0, 3) != 0);
			burst_left = $urandom_range(1, 30);
			for (int n = 0; n < PHASE_LEN; n++) begin
				if (ph == 2 && n == 30)
					hold_req = 400;
				pick = $urandom_range(0, 99);
				if (pick < 40)
					act = ACT_LOAD;
				else if (pick < 65)
					act = ACT_STORE;
				else if (pick < 95)
					act = ACT_MODIFY;
				else
					act = ACT_NONE;
				r64 = {$urandom, $urandom};
				if ($urandom_range(0, 99) < 85)
					addr = pool[$urandom_range(0, pool_n - 1)] |
						(r64[47:0] & 48'((64'd1 << cfg_offset_bits) - 1));
				else
					addr = r64[47:0];
				send_access(act, addr, 1'b0, '0);
				if (gappy) begin
					burst_left--;
					if (burst_left <= 0) begin
						pause(($urandom_range(0, 7) == 0) ? $urandom_range(1, 25) :
							$urandom_range(1, 4));
						burst_left = $urandom_range(1, 30);
					end
				end
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("set_assoc_lru_cache_model_unit regression: pass");
		else
			$display("set_assoc_lru_cache_model_unit regression: fail");
		$finish;
	end

endmodule
